// File: rtl/tps_pkg.sv
// ----------------------------------------------------------------------------
// tps_pkg
// Types and constants shared by the terrain pixel shader pipeline.
// ----------------------------------------------------------------------------
package tps_pkg;

  // Input beat: centre height and two face normals
  typedef struct packed {
    logic signed [15:0] center_height;
    logic signed [15:0] normal_a_x;
    logic signed [15:0] normal_a_y;
    logic signed [15:0] normal_a_z;
    logic signed [15:0] normal_b_x;
    logic signed [15:0] normal_b_y;
    logic signed [15:0] normal_b_z;
  } in_t;

  // Output beat: shaded colour
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } out_t;

  // Configuration register indexes
  localparam logic [2:0] CFG_SUN_DIR   = 3'd0;
  localparam logic [2:0] CFG_SUN_COL   = 3'd1;
  localparam logic [2:0] CFG_AMBIENT   = 3'd2;
  localparam logic [2:0] CFG_WATER_BASE = 3'd3;
  localparam logic [2:0] CFG_WATER_MIN = 3'd4;
  localparam logic [2:0] CFG_WATER_ABS = 3'd5;

  // Reset values of the registers
  localparam logic [47:0] SUN_DIR_RST = 48'd62938930937856;
  localparam logic [29:0] SUN_COL_RST = 30'd134348928;
  localparam logic [29:0] AMBIENT_RST = 30'd134348928;

  // Pixel class
  localparam logic [1:0] MODE_LAND    = 2'd0;
  localparam logic [1:0] MODE_SHALLOW = 2'd1;
  localparam logic [1:0] MODE_DEEP    = 2'd2;

  // Depth (Q4) at which water stops blending with the light
  localparam logic [16:0] SHALLOW_LIMIT = 17'd160;
  // Output scale
  localparam int unsigned COLOUR_SCALE = 210;
  // floor(x/5) for x below 2^14: (x*RECIP5) >> 16
  localparam logic [13:0] RECIP5 = 14'd13108;

  // Beat carried alongside the square root
  typedef struct packed {
    logic signed [34:0] num;
    logic [1:0]         mode;
    logic [7:0]         depth;
    logic [23:0]        wbytes;
  } sq_side_t;

  // Beat carried alongside the divider
  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  depth;
    logic [23:0] wbytes;
  } dv_side_t;

endpackage

// File: rtl/tps_isqrt.sv
// ----------------------------------------------------------------------------
// tps_isqrt
// Pipelined integer square root of a 34-bit value, one result bit per stage.
// ----------------------------------------------------------------------------
module tps_isqrt #(
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [33:0]       in_value,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [16:0]       out_root,
  output logic [SIDE_W-1:0] out_side
);

  localparam int STAGES = 17;

  logic [33:0]       v_s    [STAGES+1];
  logic [33:0]       r_s    [STAGES+1];
  logic [SIDE_W-1:0] side_s [STAGES+1];
  logic              vld_s  [STAGES+1];

  assign v_s[0]    = in_value;
  assign r_s[0]    = '0;
  assign side_s[0] = in_side;
  assign vld_s[0]  = in_valid;

  // One result bit per stage
  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    localparam logic [33:0] BIT = 34'd1 << (32 - 2 * k);
    logic [34:0] trial;
    logic [33:0] v_next;
    logic [33:0] r_next;

    always_comb begin
      trial = {1'b0, r_s[k]} + {1'b0, BIT};
      if ({1'b0, v_s[k]} >= trial) begin
        v_next = v_s[k] - trial[33:0];
        r_next = (r_s[k] >> 1) + BIT;
      end else begin
        v_next = v_s[k];
        r_next = r_s[k] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_s[k+1] <= 1'b0;
      end else if (en) begin
        vld_s[k+1] <= vld_s[k];
      end
      if (en) begin
        v_s[k+1]    <= v_next;
        r_s[k+1]    <= r_next;
        side_s[k+1] <= side_s[k];
      end
    end
  end

  assign out_valid = vld_s[STAGES];
  assign out_root  = r_s[STAGES][16:0];
  assign out_side  = side_s[STAGES];

endmodule

// File: rtl/tps_div.sv
// ----------------------------------------------------------------------------
// tps_div
// Pipelined signed divide by an unsigned root, truncated toward zero,
// one quotient bit per stage. A zero divisor gives zero.
// ----------------------------------------------------------------------------
module tps_div #(
  parameter int SIDE_W = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic signed [34:0] in_num,
  input  logic [16:0]        in_den,
  input  logic [SIDE_W-1:0]  in_side,
  output logic               out_valid,
  output logic signed [18:0] out_quot,
  output logic [SIDE_W-1:0]  out_side
);

  localparam int QBITS = 18;

  logic [33:0]       rem_s  [QBITS+1];
  logic [17:0]       q_s    [QBITS+1];
  logic [16:0]       den_s  [QBITS+1];
  logic              neg_s  [QBITS+1];
  logic [SIDE_W-1:0] side_s [QBITS+1];
  logic              vld_s  [QBITS+1];
  logic [34:0]       mag;

  // Work on the magnitude, restore the sign at the end
  assign mag         = in_num[34] ? 35'(-in_num) : in_num;
  assign rem_s[0]    = mag[33:0];
  assign q_s[0]      = '0;
  assign den_s[0]    = in_den;
  assign neg_s[0]    = in_num[34];
  assign side_s[0]   = in_side;
  assign vld_s[0]    = in_valid;

  for (genvar j = 0; j < QBITS; j++) begin : g_stage
    localparam int SH = QBITS - 1 - j;
    logic [33:0] dvs;
    logic [33:0] rem_next;
    logic [17:0] q_next;

    always_comb begin
      dvs = {17'd0, den_s[j]} << SH;
      if (rem_s[j] >= dvs) begin
        rem_next = rem_s[j] - dvs;
        q_next   = q_s[j] | (18'd1 << SH);
      end else begin
        rem_next = rem_s[j];
        q_next   = q_s[j];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_s[j+1] <= 1'b0;
      end else if (en) begin
        vld_s[j+1] <= vld_s[j];
      end
      if (en) begin
        rem_s[j+1]  <= rem_next;
        q_s[j+1]    <= q_next;
        den_s[j+1]  <= den_s[j];
        neg_s[j+1]  <= neg_s[j];
        side_s[j+1] <= side_s[j];
      end
    end
  end

  // Zero divisor forces zero; otherwise reapply the sign
  always_comb begin
    if (den_s[QBITS] == 17'd0) begin
      out_quot = '0;
    end else if (neg_s[QBITS]) begin
      out_quot = -$signed({1'b0, q_s[QBITS]});
    end else begin
      out_quot = $signed({1'b0, q_s[QBITS]});
    end
  end

  assign out_valid = vld_s[QBITS];
  assign out_side  = side_s[QBITS];

endmodule

// File: rtl/terrain_pixel_shader.sv
// ----------------------------------------------------------------------------
// terrain_pixel_shader
// Lambert diffuse shading of terrain pixels with shallow and deep water tint.
//
//   channel  | signals                          | payload
//   ---------+----------------------------------+-------------------------
//   input    | in_valid / in_ready              | in_data  (tps_pkg::in_t)
//   output   | out_valid / out_ready            | out_data (tps_pkg::out_t)
//   config   | cfg_valid / cfg_ready            | cfg_index, cfg_data
//
// One beat enters per cycle unless the output stalls; a result passes S1-S4,
// the 17-stage square root, 18-stage divider, L1-L4 and the output register.
// A stall on the output freezes every stage at once; in_ready is low then.
// Synchronous reset clears valid bits and reloads the register defaults.
// cfg_ready is always high.
// ----------------------------------------------------------------------------
module terrain_pixel_shader #(
  parameter int WATER_DEPTH_LEVELS = 1024
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  tps_pkg::in_t in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output tps_pkg::out_t out_data,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [47:0]  cfg_data
);

  import tps_pkg::*;

  localparam int IW = $clog2(WATER_DEPTH_LEVELS);
  localparam int VW = 16 + IW + 2;
  localparam logic [IW-1:0] IDX_MAX = IW'(WATER_DEPTH_LEVELS - 1);

  // ---------------- configuration registers ----------------
  logic [47:0] sun_direction;
  logic [29:0] sun_color_rgb;
  logic [29:0] ambient_rgb;
  logic [29:0] water_base_rgb;
  logic [29:0] water_min_rgb;
  logic [47:0] water_absorb_rgb;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sun_direction    <= SUN_DIR_RST;
      sun_color_rgb    <= SUN_COL_RST;
      ambient_rgb      <= AMBIENT_RST;
      water_base_rgb   <= '0;
      water_min_rgb    <= '0;
      water_absorb_rgb <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SUN_DIR:    sun_direction    <= cfg_data;
        CFG_SUN_COL:    sun_color_rgb    <= cfg_data[29:0];
        CFG_AMBIENT:    ambient_rgb      <= cfg_data[29:0];
        CFG_WATER_BASE: water_base_rgb   <= cfg_data[29:0];
        CFG_WATER_MIN:  water_min_rgb    <= cfg_data[29:0];
        CFG_WATER_ABS:  water_absorb_rgb <= cfg_data;
        default: ;
      endcase
    end
  end

  // Whole pipeline advances together
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // ---------------- S1: normal sum, depth, class ----------------
  logic               s1_valid;
  logic signed [16:0] s1_n [3];
  logic [1:0]         s1_mode;
  logic [7:0]         s1_depth;
  logic [IW-1:0]      s1_idx;

  logic [16:0]        in_d;
  logic [12:0]        in_raw_idx;
  logic [1:0]         in_mode;
  logic [IW-1:0]      in_idx;

  always_comb begin
    in_d       = 17'(-$signed({in_data.center_height[15], in_data.center_height}));
    in_raw_idx = in_d[16:4];
    if (!in_data.center_height[15]) begin
      in_mode = MODE_LAND;
    end else if (in_d < SHALLOW_LIMIT) begin
      in_mode = MODE_SHALLOW;
    end else begin
      in_mode = MODE_DEEP;
    end
    if (32'(in_raw_idx) > 32'(IDX_MAX)) begin
      in_idx = IDX_MAX;
    end else begin
      in_idx = IW'(in_raw_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
    if (en) begin
      s1_n[0]  <= 17'(in_data.normal_a_x) + 17'(in_data.normal_b_x);
      s1_n[1]  <= 17'(in_data.normal_a_y) + 17'(in_data.normal_b_y);
      s1_n[2]  <= 17'(in_data.normal_a_z) + 17'(in_data.normal_b_z);
      s1_mode  <= in_mode;
      s1_depth <= in_d[7:0];
      s1_idx   <= in_idx;
    end
  end

  // ---------------- S2: squares, sun products, absorption ----------------
  logic               s2_valid;
  logic [32:0]        s2_sq [3];
  logic signed [32:0] s2_pr [3];
  logic [16+IW-1:0]   s2_ab [3];
  logic [1:0]         s2_mode;
  logic [7:0]         s2_depth;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        s2_sq[c] <= 33'(34'(s1_n[c]) * 34'(s1_n[c]));
        s2_pr[c] <= $signed(sun_direction[16*c +: 16]) * s1_n[c];
        s2_ab[c] <= water_absorb_rgb[16*c +: 16] * s1_idx;
      end
      s2_mode  <= s1_mode;
      s2_depth <= s1_depth;
    end
  end

  // ---------------- S3: sums, depth colour floor ----------------
  logic               s3_valid;
  logic [33:0]        s3_sq;
  logic signed [34:0] s3_num;
  logic [17:0]        s3_v [3];
  logic [1:0]         s3_mode;
  logic [7:0]         s3_depth;
  logic signed [VW-1:0] v_raw [3];
  logic signed [VW-1:0] v_min [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      v_raw[c] = $signed(VW'({water_base_rgb[10*c +: 10], 8'd0})) - $signed(VW'(s2_ab[c]));
      v_min[c] = $signed(VW'({water_min_rgb[10*c +: 10], 8'd0}));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
    end
    if (en) begin
      s3_sq  <= 34'(s2_sq[0]) + 34'(s2_sq[1]) + 34'(s2_sq[2]);
      s3_num <= 35'(s2_pr[0]) + 35'(s2_pr[1]) + 35'(s2_pr[2]);
      for (int c = 0; c < 3; c++) begin
        s3_v[c] <= (v_raw[c] < v_min[c]) ? v_min[c][17:0] : v_raw[c][17:0];
      end
      s3_mode  <= s2_mode;
      s3_depth <= s2_depth;
    end
  end

  // ---------------- S4: depth colour bytes ----------------
  logic               s4_valid;
  logic [33:0]        s4_sq;
  sq_side_t           s4_side;
  logic [25:0]        wprod [3];
  logic [23:0]        wb_next;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      wprod[c] = 26'(s3_v[c]) * 26'(COLOUR_SCALE);
      wb_next[8*c +: 8] = (wprod[c][25:16] > 10'd255) ? 8'hFF : wprod[c][23:16];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (en) begin
      s4_valid <= s3_valid;
    end
    if (en) begin
      s4_sq          <= s3_sq;
      s4_side.num    <= s3_num;
      s4_side.mode   <= s3_mode;
      s4_side.depth  <= s3_depth;
      s4_side.wbytes <= wb_next;
    end
  end

  // ---------------- length and normalised dot product ----------------
  logic        sq_valid;
  logic [16:0] sq_root;
  sq_side_t    sq_side;

  tps_isqrt #(.SIDE_W($bits(sq_side_t))) u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s4_valid),
    .in_value  (s4_sq),
    .in_side   (s4_side),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  logic               dv_valid;
  logic signed [18:0] dv_dot;
  dv_side_t           dv_in_side;
  dv_side_t           dv_side;

  assign dv_in_side.mode   = sq_side.mode;
  assign dv_in_side.depth  = sq_side.depth;
  assign dv_in_side.wbytes = sq_side.wbytes;

  tps_div #(.SIDE_W($bits(dv_side_t))) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sq_valid),
    .in_num    (sq_side.num),
    .in_den    (sq_root),
    .in_side   (dv_in_side),
    .out_valid (dv_valid),
    .out_quot  (dv_dot),
    .out_side  (dv_side)
  );

  // ---------------- L1: sun colour times dot ----------------
  logic               l1_valid;
  logic signed [29:0] l1_lc [3];
  dv_side_t           l1_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      l1_valid <= 1'b0;
    end else if (en) begin
      l1_valid <= dv_valid;
    end
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        l1_lc[c] <= $signed({1'b0, sun_color_rgb[10*c +: 10]}) * dv_dot;
      end
      l1_side <= dv_side;
    end
  end

  // ---------------- L2: clamp, add ambient, clamp ----------------
  logic        l2_valid;
  logic [22:0] l2_lt [3];
  dv_side_t    l2_side;
  logic [29:0] lsum [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      lsum[c] = (l1_lc[c] < 0 ? 30'd0 : 30'(l1_lc[c]))
              + {6'd0, ambient_rgb[10*c +: 10], 14'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      l2_valid <= 1'b0;
    end else if (en) begin
      l2_valid <= l1_valid;
    end
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        l2_lt[c] <= (lsum[c] > 30'(1 << 22)) ? 23'(1 << 22) : lsum[c][22:0];
      end
      l2_side <= l1_side;
    end
  end

  // ---------------- L3: scale light ----------------
  logic        l3_valid;
  logic [30:0] l3_ls [3];
  dv_side_t    l3_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      l3_valid <= 1'b0;
    end else if (en) begin
      l3_valid <= l2_valid;
    end
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        l3_ls[c] <= 31'(l2_lt[c]) * 31'(COLOUR_SCALE);
      end
      l3_side <= l2_side;
    end
  end

  // ---------------- L4: land bytes and water blend sums ----------------
  logic        l4_valid;
  logic [7:0]  l4_land [3];
  logic [17:0] l4_blend [3];
  logic [15:0] l4_asum;
  dv_side_t    l4_side;
  logic [7:0]  dm;
  logic [38:0] lw [3];

  always_comb begin
    dm = 8'(SHALLOW_LIMIT[7:0] - l3_side.depth);
    for (int c = 0; c < 3; c++) begin
      lw[c] = 39'(l3_ls[c]) * 39'(dm);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      l4_valid <= 1'b0;
    end else if (en) begin
      l4_valid <= l3_valid;
    end
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        l4_land[c]  <= l3_ls[c][29:22];
        l4_blend[c] <= 18'(l3_side.wbytes[8*c +: 8]) * 18'(l3_side.depth)
                     + 18'(lw[c][38:22]);
      end
      l4_asum <= 16'(dm) * 16'd255;
      l4_side <= l3_side;
    end
  end

  // ---------------- output register: divide by 160 and select ----------------
  logic [1:0]  out_mode;
  logic [26:0] bq [3];
  logic [26:0] aq;
  logic [7:0]  sb [3];
  out_t        out_next;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      bq[c] = 27'(l4_blend[c][17:5]) * 27'(RECIP5);
      sb[c] = (bq[c][26:16] > 11'd255) ? 8'hFF : bq[c][23:16];
    end
    aq = 27'(l4_asum[15:5]) * 27'(RECIP5);
    unique case (l4_side.mode)
      MODE_LAND: begin
        out_next = '{red: l4_land[0], green: l4_land[1], blue: l4_land[2], alpha: 8'hFF};
      end
      MODE_SHALLOW: begin
        out_next = '{red: sb[0], green: sb[1], blue: sb[2], alpha: aq[23:16]};
      end
      default: begin
        out_next = '{red: l4_side.wbytes[7:0], green: l4_side.wbytes[15:8],
                     blue: l4_side.wbytes[23:16], alpha: 8'd0};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= l4_valid;
    end
    if (en) begin
      out_data <= out_next;
      out_mode <= l4_side.mode;
    end
  end

  // ---------------- checks ----------------
  a_land_opaque: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_mode == MODE_LAND) == (out_data.alpha == 8'hFF)))
    else $error("alpha 255 does not match land class");

  a_land_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_mode == MODE_LAND |->
      out_data.red <= 8'd210 && out_data.green <= 8'd210 && out_data.blue <= 8'd210)
    else $error("land colour above full scale");

  a_deep_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_mode == MODE_DEEP |-> out_data.alpha == 8'd0)
    else $error("deep water not transparent");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en && l4_valid |=> l4_valid && $stable(l4_blend[0]) && $stable(l4_land[0]))
    else $error("pipeline moved during stall");

endmodule
